### rtl/core/jsu_pkg.sv
// Shared types, codes and helpers for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  // Capacity limits of the output buffer
  localparam logic [12:0] CapMax   = 13'd4096;
  localparam logic [12:0] CapReset = 13'd128;

  // Most results one request can raise
  localparam int unsigned MaxRes = 3;

  // Characters with a meaning of their own
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChU      = 8'h75;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_string;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      out_kind;
    logic       last;
  } out_item_t;

  // Results raised by one request, item 0 first
  typedef struct packed {
    logic [1:0]                 cnt;
    out_item_t [MaxRes-1:0]     items;
  } res_grp_t;

  // Status of the result queue towards the input side
  typedef struct packed {
    logic busy;
    logic freeing;
  } q_stat_t;

  function automatic out_item_t mk_res(logic [7:0] b, kind_e k, logic l);
    out_item_t r;
    r.out_byte = b;
    r.out_kind = k;
    r.last     = l;
    return r;
  endfunction

endpackage

### rtl/core/jsu_decoder.sv
// Decoder state and single-pass decode of one request into a result group.
`timescale 1ns / 1ps

module jsu_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  jsu_pkg::in_item_t  item_i,
  input  logic               cfg_we_i,
  input  logic [12:0]        cfg_wdata_i,
  output jsu_pkg::res_grp_t  grp_o
);
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TEXT = 4'b0010,
    PH_ESC  = 4'b0100,
    PH_HEX  = 4'b1000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] hex_q, hex_d;
  logic [1:0]  seen_q, seen_d;
  logic [11:0] bw_q, bw_d;
  logic [12:0] cap_q;

  logic [12:0] cap_eff;
  logic        fit1, fit2, fit3;
  logic        esc_ok;
  logic [7:0]  esc_c;
  logic        dig_ok;
  logic [3:0]  dig;
  logic [15:0] cp;
  logic [7:0]  b;

  assign b = item_i.in_byte;

  // Clamp capacity and work out what still fits
  assign cap_eff = (cap_q > CapMax) ? CapMax : cap_q;
  assign fit1 = ({2'b00, bw_q} + 14'd1) < {1'b0, cap_eff};
  assign fit2 = ({2'b00, bw_q} + 14'd2) < {1'b0, cap_eff};
  assign fit3 = ({2'b00, bw_q} + 14'd3) < {1'b0, cap_eff};

  // Map a single-character escape
  always_comb begin
    esc_ok = 1'b1;
    esc_c  = 8'h00;
    unique case (b)
      ChQuote:  esc_c = ChQuote;
      ChBslash: esc_c = ChBslash;
      ChSlash:  esc_c = ChSlash;
      8'h6E:    esc_c = 8'h0A;
      8'h72:    esc_c = 8'h0D;
      8'h74:    esc_c = 8'h09;
      8'h62:    esc_c = 8'h08;
      8'h66:    esc_c = 8'h0C;
      default:  esc_ok = 1'b0;
    endcase
  end

  // Hex digit of either case
  always_comb begin
    dig_ok = 1'b1;
    dig    = 4'h0;
    if (b >= 8'h30 && b <= 8'h39) begin
      dig = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      dig = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      dig = 4'(b - 8'h37);
    end else begin
      dig_ok = 1'b0;
    end
  end

  assign cp = {hex_q[11:0], dig};

  // Next state and results of this request
  always_comb begin
    phase_d = phase_q;
    hex_d   = hex_q;
    seen_d  = seen_q;
    bw_d    = bw_q;
    grp_o   = '0;
    if (item_i.start_string) begin
      hex_d  = '0;
      seen_d = '0;
      bw_d   = '0;
      if (item_i.end_of_input || b != ChQuote) begin
        phase_d = PH_IDLE;
        grp_o.cnt = 2'd1;
        grp_o.items[0] = mk_res(8'h00, KIND_ERR, 1'b1);
      end else begin
        phase_d = PH_TEXT;
      end
    end else if (phase_q != PH_IDLE && item_i.end_of_input) begin
      phase_d = PH_IDLE;
      grp_o.cnt = 2'd1;
      grp_o.items[0] = mk_res(8'h00, KIND_ERR, 1'b1);
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          phase_d = PH_IDLE;
        end
        PH_TEXT: begin
          grp_o.cnt = 2'd1;
          if (b == ChQuote) begin
            phase_d = PH_IDLE;
            grp_o.items[0] = mk_res(8'h00, KIND_DONE, 1'b1);
          end else if (b == ChBslash) begin
            phase_d   = PH_ESC;
            grp_o.cnt = 2'd0;
          end else if (!fit1) begin
            phase_d = PH_IDLE;
            grp_o.items[0] = mk_res(8'h00, KIND_ERR, 1'b1);
          end else begin
            bw_d = bw_q + 12'd1;
            grp_o.items[0] = mk_res(b, KIND_DATA, 1'b1);
          end
        end
        PH_ESC: begin
          if (b == ChU) begin
            phase_d = PH_HEX;
            hex_d   = '0;
            seen_d  = '0;
          end else begin
            grp_o.cnt = 2'd1;
            if (esc_ok && fit1) begin
              phase_d = PH_TEXT;
              bw_d    = bw_q + 12'd1;
              grp_o.items[0] = mk_res(esc_c, KIND_DATA, 1'b1);
            end else begin
              phase_d = PH_IDLE;
              grp_o.items[0] = mk_res(8'h00, KIND_ERR, 1'b1);
            end
          end
        end
        PH_HEX: begin
          if (!dig_ok) begin
            phase_d = PH_IDLE;
            grp_o.cnt = 2'd1;
            grp_o.items[0] = mk_res(8'h00, KIND_ERR, 1'b1);
          end else if (seen_q != 2'd3) begin
            hex_d  = cp;
            seen_d = seen_q + 2'd1;
          end else begin
            // Emit the code point as UTF-8, drop it if it does not fit
            hex_d   = '0;
            seen_d  = '0;
            phase_d = PH_TEXT;
            if (cp < 16'h0080) begin
              if (fit1) begin
                grp_o.cnt = 2'd1;
                bw_d = bw_q + 12'd1;
                grp_o.items[0] = mk_res(cp[7:0], KIND_DATA, 1'b1);
              end
            end else if (cp < 16'h0800) begin
              if (fit2) begin
                grp_o.cnt = 2'd2;
                bw_d = bw_q + 12'd2;
                grp_o.items[0] = mk_res(8'hC0 | {3'b000, cp[10:6]}, KIND_DATA, 1'b0);
                grp_o.items[1] = mk_res(8'h80 | {2'b00, cp[5:0]}, KIND_DATA, 1'b1);
              end
            end else begin
              if (fit3) begin
                grp_o.cnt = 2'd3;
                bw_d = bw_q + 12'd3;
                grp_o.items[0] = mk_res(8'hE0 | {4'h0, cp[15:12]}, KIND_DATA, 1'b0);
                grp_o.items[1] = mk_res(8'h80 | {2'b00, cp[11:6]}, KIND_DATA, 1'b0);
                grp_o.items[2] = mk_res(8'h80 | {2'b00, cp[5:0]}, KIND_DATA, 1'b1);
              end
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Advance decoder state on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hex_q   <= '0;
      seen_q  <= '0;
      bw_q    <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      seen_q  <= seen_d;
      bw_q    <= bw_d;
    end
  end

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

endmodule

### rtl/core/jsu_res_queue.sv
// Result register that holds one group and hands its items out one by one.
`timescale 1ns / 1ps

module jsu_res_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  jsu_pkg::res_grp_t  grp_i,
  output jsu_pkg::q_stat_t   stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jsu_pkg::out_item_t out_o
);
  import jsu_pkg::*;

  logic     busy_q;
  logic [1:0] idx_q;
  res_grp_t grp_q;
  logic     take;
  logic     fin;

  assign take = busy_q && !out_stall_i;
  assign fin  = take && (idx_q == (grp_q.cnt - 2'd1));

  assign stat_o.busy    = busy_q;
  assign stat_o.freeing = fin;
  assign out_valid_o    = busy_q;
  assign out_o          = grp_q.items[idx_q];

  // Track which item of the group is on offer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
    end else if (fin) begin
      busy_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  // Hold the group payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_i;
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!busy_q || fin))
    else $error("group loaded over one still pending");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < grp_q.cnt))
    else $error("item index beyond group size");
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (out_o.last == (idx_q == (grp_q.cnt - 2'd1))))
    else $error("last flag does not mark the final item");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin && !load_i) |=> !busy_q)
    else $error("queue still busy after final item taken");
`endif

endmodule

### rtl/core/json_string_unescaper_unit.sv
// Top level of the JSON string unescaper.
`timescale 1ns / 1ps

// Decodes one quoted JSON string, one byte per request, into its UTF-8 bytes,
// a done result on the closing quote, or an error result. A request is taken
// every cycle while the result register is free or handing out the final item
// of its group; a request raises zero to three results, which the output side
// hands out one by one, so a \u escape that expands to two or three bytes
// holds the input until its final byte is taken. The capacity register may
// be written at any idle time and takes effect on the next request.
module json_string_unescaper_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jsu_pkg::in_item_t  in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jsu_pkg::out_item_t out_o,
  input  logic               cfg_we_i,
  input  logic [12:0]        cfg_wdata_i
);
  import jsu_pkg::*;

  res_grp_t grp;
  q_stat_t  stat;
  logic     fire;

  // Accept when the result register is free or frees this cycle
  assign in_stall_o = stat.busy && !stat.freeing;
  assign fire       = in_valid_i && !in_stall_o;

  jsu_decoder u_dec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (in_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .grp_o       (grp)
  );

  jsu_res_queue u_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && (grp.cnt != 2'd0)),
    .grp_i       (grp),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

endmodule
